@@ hdl/acbc_pkg.sv @@
// Shared types, constants and GF(2^8) helpers for the AES-256 CBC decrypt core.
// The S-box tables are built at elaboration from the field arithmetic below.
// Depends on nothing.
`timescale 1ns / 1ps

package acbc_pkg;

   localparam int NumRounds = 14;
   localparam int NumStages = NumRounds + 1;
   localparam int KeyWords  = 4 * (NumRounds + 1);

   typedef enum logic [2:0] {
      CSR_KEY_WORD_0      = 3'd0,
      CSR_KEY_WORD_1      = 3'd1,
      CSR_KEY_WORD_2      = 3'd2,
      CSR_KEY_WORD_3      = 3'd3,
      CSR_INIT_VECTOR_HI  = 3'd4,
      CSR_INIT_VECTOR_LO  = 3'd5
   } csr_index_type;

   typedef logic [7:0]          byte_table_type [256];
   typedef logic [127:0]        block_type;
   typedef logic [3:0][31:0]    round_key_type;

   typedef struct packed {
      logic busy;
      logic loading;
   } kx_status_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h00;
      p = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ p;
         p = xtime(p);
      end
      return r;
   endfunction

   // x^254, so zero maps to zero.
   function automatic logic [7:0] gf_inv(input logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      logic [7:0] e;
      r = 8'h01;
      p = x;
      e = 8'd254;
      for (int i = 0; i < 8; i++) begin
         if (e[i]) r = gf_mul(r, p);
         p = gf_mul(p, p);
      end
      return r;
   endfunction

   function automatic logic [7:0] rotl8(input logic [7:0] v, input int n);
      return 8'((v << n) | (v >> (8 - n)));
   endfunction

   function automatic byte_table_type gen_sbox();
      byte_table_type t;
      logic [7:0] b;
      for (int i = 0; i < 256; i++) begin
         b = gf_inv(8'(i));
         t[i] = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
      end
      return t;
   endfunction

   function automatic byte_table_type gen_inv_sbox();
      byte_table_type t;
      logic [7:0] s;
      for (int i = 0; i < 256; i++) begin
         s = 8'(i);
         t[i] = gf_inv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
      end
      return t;
   endfunction

   localparam byte_table_type SBOX     = gen_sbox();
   localparam byte_table_type INV_SBOX = gen_inv_sbox();

   function automatic logic [31:0] sbox_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // Byte 0 of the state sits in bits 127..120.
   function automatic block_type inv_shift_sub(input block_type s);
      block_type o;
      int src;
      o = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = 4 * ((c - r) & 3) + r;
            o[127 - 8 * (4 * c + r) -: 8] = INV_SBOX[s[127 - 8 * src -: 8]];
         end
      end
      return o;
   endfunction

   function automatic logic [31:0] inv_mix_column(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24];
      a1 = c[23:16];
      a2 = c[15:8];
      a3 = c[7:0];
      return {gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13) ^ gf_mul(a3, 8'd9),
              gf_mul(a0, 8'd9)  ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11) ^ gf_mul(a3, 8'd13),
              gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9)  ^ gf_mul(a2, 8'd14) ^ gf_mul(a3, 8'd11),
              gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)  ^ gf_mul(a3, 8'd14)};
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type o;
      for (int c = 0; c < 4; c++) begin
         o[127 - 32 * c -: 32] = inv_mix_column(s[127 - 32 * c -: 32]);
      end
      return o;
   endfunction

endpackage

@@ hdl/acbc_channels.sv @@
// Valid/ready channel interfaces for the ciphertext requests and plaintext responses.
// Depends on nothing.
`timescale 1ns / 1ps

interface acbc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] cipher_high;
   logic [63:0] cipher_low;
   logic        first_block;

   modport source (output valid, cipher_high, cipher_low, first_block, input ready);
   modport sink   (input valid, cipher_high, cipher_low, first_block, output ready);
endinterface

interface acbc_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] plain_high;
   logic [63:0] plain_low;

   modport source (output valid, plain_high, plain_low, input ready);
   modport sink   (input valid, plain_high, plain_low, output ready);
endinterface

@@ hdl/aes256_cbc_decrypt_core.sv @@
// Top level of the AES-256 CBC decrypt core: CSRs, chaining and the round pipeline.
// Depends on acbc_pkg, acbc_channels and acbc_key_expand.
`timescale 1ns / 1ps
//
//  Channel  Direction  Beat payload
//  req      in         cipher_high, cipher_low, first_block
//  rsp      out        plain_high, plain_low
//  csr      in         csr_write_en, csr_index, csr_wdata (write only)
//
// One block enters per cycle unless rsp.ready or the key schedule stalls it; each
// stage after stage 0 does one inverse round. After a key word write the key schedule
// runs, one word per cycle, and req.ready stays low meanwhile. Reset is synchronous
// and clears the key, IV and chaining registers; round keys are unknown until a key
// write. Each stage holds its beat while the stage after it is full and stalled.

module aes256_cbc_decrypt_core (
   input  logic              clock,
   input  logic              reset,
   acbc_req_if.sink          req,
   acbc_rsp_if.source        rsp,
   input  logic              csr_write_en,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_wdata
);
   import acbc_pkg::*;

   logic [3:0][63:0] key_ff;
   logic [1:0][63:0] iv_ff;
   logic [127:0]     chain_ff;
   logic             kx_start_ff;

   kx_status_type    kx_status;
   round_key_type [NumStages-1:0] rk;

   logic [NumStages-1:0] v_ff;
   logic [NumStages-1:0] adv;
   block_type            st_ff [NumStages];
   block_type            cv_ff [NumStages-1];
   block_type            cv_in;
   logic                 accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff      <= '0;
         iv_ff       <= '0;
         kx_start_ff <= 1'b0;
      end else begin
         kx_start_ff <= 1'b0;
         if (csr_write_en) begin
            unique case (csr_index_type'(csr_index)) inside
               CSR_KEY_WORD_0, CSR_KEY_WORD_1, CSR_KEY_WORD_2, CSR_KEY_WORD_3: begin
                  key_ff[csr_index[1:0]] <= csr_wdata;
                  kx_start_ff            <= 1'b1;
               end
               CSR_INIT_VECTOR_HI: iv_ff[0] <= csr_wdata;
               CSR_INIT_VECTOR_LO: iv_ff[1] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   acbc_key_expand u_key_expand (
      .clock      (clock),
      .reset      (reset),
      .start      (kx_start_ff),
      .key        (key_ff),
      .status     (kx_status),
      .round_keys (rk)
   );

   // A stage takes a new beat when it is empty or its content moves on.
   always_comb begin
      adv[NumStages-1] = !v_ff[NumStages-1] || rsp.ready;
      for (int k = NumStages - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
   end

   assign req.ready = adv[0] && !kx_status.busy;
   assign accept    = req.valid && req.ready;
   assign cv_in     = req.first_block ? {iv_ff[0], iv_ff[1]} : chain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         chain_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= accept;
         for (int k = 1; k < NumStages; k++) begin
            if (adv[k]) v_ff[k] <= v_ff[k-1];
         end
         if (accept) chain_ff <= {req.cipher_high, req.cipher_low};
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         st_ff[0] <= {req.cipher_high, req.cipher_low} ^ rk[0];
         cv_ff[0] <= cv_in;
      end
      for (int k = 1; k < NumStages - 1; k++) begin
         if (adv[k]) begin
            st_ff[k] <= inv_mix(inv_shift_sub(st_ff[k-1]) ^ rk[k]);
            cv_ff[k] <= cv_ff[k-1];
         end
      end
      // Last round has no column mix; the chaining value is folded in here.
      if (adv[NumStages-1]) begin
         st_ff[NumStages-1] <= inv_shift_sub(st_ff[NumStages-2]) ^ rk[NumStages-1]
                               ^ cv_ff[NumStages-2];
      end
   end

   assign rsp.valid      = v_ff[NumStages-1];
   assign rsp.plain_high = st_ff[NumStages-1][127:64];
   assign rsp.plain_low  = st_ff[NumStages-1][63:0];

   a_no_accept_during_expand: assert property (@(posedge clock) disable iff (reset)
      kx_status.busy |-> !req.ready)
      else $error("request taken while the key schedule runs");

   a_key_write_starts_expand: assert property (@(posedge clock) disable iff (reset)
      csr_write_en && (csr_index_type'(csr_index) == CSR_KEY_WORD_0 ||
                       csr_index_type'(csr_index) == CSR_KEY_WORD_3)
      |=> kx_status.loading)
      else $error("key write did not restart the key schedule");

   a_accept_fills_stage0: assert property (@(posedge clock) disable iff (reset)
      accept |=> v_ff[0])
      else $error("accepted beat missing from the first stage");

endmodule

@@ hdl/acbc_key_expand.sv @@
// Iterative AES-256 key schedule, one 32-bit word per cycle, stored in decryption order.
// Depends on acbc_pkg.
`timescale 1ns / 1ps

module acbc_key_expand (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [3:0][63:0]                       key,
   output acbc_pkg::kx_status_type                status,
   output acbc_pkg::round_key_type [acbc_pkg::NumStages-1:0] round_keys
);
   import acbc_pkg::*;

   logic [7:0][31:0] win_ff;
   logic [5:0]       cnt_ff;
   logic [7:0]       rcon_ff;
   logic             busy_ff;
   round_key_type [NumStages-1:0] rk_ff;

   logic [31:0] temp_in;
   logic [31:0] word_in;
   logic [3:0]  slot_in;

   always_comb begin
      temp_in = win_ff[7];
      if (cnt_ff[2:0] == 3'd0) begin
         temp_in = sbox_word({win_ff[7][23:0], win_ff[7][31:24]}) ^ {rcon_ff, 24'h0};
      end else if (cnt_ff[2:0] == 3'd4) begin
         temp_in = sbox_word(win_ff[7]);
      end
      word_in = win_ff[0] ^ temp_in;
      // The last encryption round key lands in slot 0.
      slot_in = 4'(NumRounds) - cnt_ff[5:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         rcon_ff <= 8'h01;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 6'd8;
         rcon_ff <= 8'h01;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff[2:0] == 3'd0) rcon_ff <= xtime(rcon_ff);
         if (cnt_ff == 6'(KeyWords - 1)) busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         win_ff <= {key[3][31:0], key[3][63:32], key[2][31:0], key[2][63:32],
                    key[1][31:0], key[1][63:32], key[0][31:0], key[0][63:32]};
         rk_ff[NumRounds]     <= {key[0], key[1]};
         rk_ff[NumRounds - 1] <= {key[2], key[3]};
      end else if (busy_ff) begin
         win_ff <= {word_in, win_ff[7:1]};
         rk_ff[slot_in][2'd3 - cnt_ff[1:0]] <= word_in;
      end
   end

   assign status.busy    = busy_ff | start;
   assign status.loading = start;
   assign round_keys     = rk_ff;

endmodule

@@ tb/aes256_cbc_decrypt_core_testbench.sv @@
// Self-checking testbench for the AES-256 CBC decrypt core: directed and random
// ciphertext beats with random gaps and response stalls, checked against a local model.
// Depends on acbc_pkg, acbc_channels and aes256_cbc_decrypt_core.
`timescale 1ns / 1ps

module testbench;
   import acbc_pkg::*;

   typedef struct {
      logic [63:0] cipher_high;
      logic [63:0] cipher_low;
      logic        first_block;
   } cipher_beat_type;

   typedef struct {
      logic [63:0] plain_high;
      logic [63:0] plain_low;
   } plain_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;

   acbc_req_if req ();
   acbc_rsp_if rsp ();

   aes256_cbc_decrypt_core i_dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Model state: key, IV, chaining value and decryption-order round keys.
   logic [63:0]  key_words [4];
   logic [63:0]  iv_words [2];
   logic [63:0]  prev_cipher [2];
   logic [127:0] dec_keys [15];

   cipher_beat_type pending_ciphers [$];
   plain_beat_type  expected_plain [$];
   int     errors = 0;
   int     beats_checked = 0;
   int     firsts_sent = 0;
   longint cycle_count = 0;
   bit     req_taken = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("%0t: timeout with %0d beats outstanding", $time, expected_plain.size());
         $display("aes256_cbc_decrypt_core regression: fail");
         $finish;
      end
   end

   function automatic logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] r;
      r = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      end
      return r;
   endfunction

   function automatic logic [7:0] field_inv(logic [7:0] x);
      logic [7:0] r;
      logic [7:0] p;
      r = 8'h01;
      p = x;
      for (int i = 1; i < 8; i++) begin
         p = field_mul(p, p);
         r = field_mul(r, p);
      end
      return r;
   endfunction

   function automatic logic [7:0] rol8(logic [7:0] v, int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   function automatic logic [7:0] fwd_sbox(logic [7:0] x);
      logic [7:0] b;
      b = field_inv(x);
      return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
   endfunction

   function automatic logic [7:0] rev_sbox(logic [7:0] s);
      return field_inv(rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05);
   endfunction

   task automatic rebuild_schedule();
      logic [31:0] w [60];
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 4; i++) begin
         w[2 * i] = key_words[i][63:32];
         w[2 * i + 1] = key_words[i][31:0];
      end
      for (int i = 8; i < 60; i++) begin
         t = w[i - 1];
         if (i % 8 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sbox(t[31:24]), fwd_sbox(t[23:16]), fwd_sbox(t[15:8]), fwd_sbox(t[7:0])};
            t[31:24] ^= rcon;
            rcon = {rcon[6:0], 1'b0} ^ (rcon[7] ? 8'h1b : 8'h00);
         end else if (i % 8 == 4) begin
            t = {fwd_sbox(t[31:24]), fwd_sbox(t[23:16]), fwd_sbox(t[15:8]), fwd_sbox(t[7:0])};
         end
         w[i] = w[i - 8] ^ t;
      end
      for (int r = 0; r <= 14; r++) begin
         dec_keys[r] = {w[4 * (14 - r)], w[4 * (14 - r) + 1], w[4 * (14 - r) + 2],
                        w[4 * (14 - r) + 3]};
      end
   endtask

   function automatic logic [127:0] unshift_unsub(logic [127:0] s);
      logic [127:0] o;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            o[127 - 8 * (4 * c + r) -: 8] = rev_sbox(s[127 - 8 * (4 * ((c - r) & 3) + r) -: 8]);
         end
      end
      return o;
   endfunction

   function automatic logic [127:0] unmix(logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a [4];
      for (int c = 0; c < 4; c++) begin
         for (int j = 0; j < 4; j++) a[j] = s[127 - 8 * (4 * c + j) -: 8];
         for (int j = 0; j < 4; j++) begin
            o[127 - 8 * (4 * c + j) -: 8] =
               field_mul(a[j], 8'd14) ^ field_mul(a[(j + 1) % 4], 8'd11) ^
               field_mul(a[(j + 2) % 4], 8'd13) ^ field_mul(a[(j + 3) % 4], 8'd9);
         end
      end
      return o;
   endfunction

   function automatic plain_beat_type decrypt_block(cipher_beat_type c);
      logic [127:0] s;
      logic [127:0] chain;
      plain_beat_type p;
      chain = c.first_block ? {iv_words[0], iv_words[1]} : {prev_cipher[0], prev_cipher[1]};
      s = {c.cipher_high, c.cipher_low} ^ dec_keys[0];
      for (int r = 1; r < 14; r++) s = unmix(unshift_unsub(s) ^ dec_keys[r]);
      s = unshift_unsub(s) ^ dec_keys[14] ^ chain;
      p.plain_high = s[127:64];
      p.plain_low = s[63:0];
      prev_cipher[0] = c.cipher_high;
      prev_cipher[1] = c.cipher_low;
      return p;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Driver: the mode flags let whole phases run without gaps or stalls.
   bit send_gaps = 1;
   bit recv_stalls = 1;
   int send_wait = 0;
   int stall_wait = 0;
   cipher_beat_type current_beat;

   initial begin
      req.valid = 1'b0;
      req.cipher_high = '0;
      req.cipher_low = '0;
      req.first_block = 1'b0;
      rsp.ready = 1'b0;
   end

   // A beat that was offered and not taken at the last rising edge is held as it is.
   always @(negedge clock) begin
      int gap;
      int stall;
      if (!reset) begin
         if (req.valid && !req_taken) begin
            req.valid <= 1'b1;
         end else if (send_wait > 0) begin
            send_wait <= send_wait - 1;
            req.valid <= 1'b0;
         end else if (pending_ciphers.size() == 0) begin
            req.valid <= 1'b0;
         end else begin
            gap = send_gaps ? pick_gap() : 0;
            if (gap > 0) begin
               send_wait <= gap - 1;
               req.valid <= 1'b0;
            end else begin
               current_beat = pending_ciphers[0];
               req.valid <= 1'b1;
               req.cipher_high <= current_beat.cipher_high;
               req.cipher_low <= current_beat.cipher_low;
               req.first_block <= current_beat.first_block;
            end
         end
         if (stall_wait > 0) begin
            stall_wait <= stall_wait - 1;
            rsp.ready <= 1'b0;
         end else begin
            stall = recv_stalls ? pick_gap() : 0;
            if (stall > 0) begin
               stall_wait <= stall - 1;
               rsp.ready <= 1'b0;
            end else begin
               rsp.ready <= 1'b1;
            end
         end
      end
   end

   // Monitor: predict on accepted requests, check accepted responses.
   always @(posedge clock) begin
      plain_beat_type want;
      cipher_beat_type seen;
      req_taken = 1'b0;
      if (!reset) begin
         if (req.valid && req.ready) begin
            req_taken = 1'b1;
            seen.cipher_high = req.cipher_high;
            seen.cipher_low = req.cipher_low;
            seen.first_block = req.first_block;
            void'(pending_ciphers.pop_front());
            expected_plain.push_back(decrypt_block(seen));
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_plain.size() == 0) begin
               $display("%0t: unexpected plaintext beat %h %h", $time, rsp.plain_high,
                        rsp.plain_low);
               errors++;
            end else begin
               want = expected_plain.pop_front();
               if (rsp.plain_high !== want.plain_high) begin
                  $display("%0t: plain_high expected %h actual %h", $time, want.plain_high,
                           rsp.plain_high);
                  errors++;
               end
               if (rsp.plain_low !== want.plain_low) begin
                  $display("%0t: plain_low expected %h actual %h", $time, want.plain_low,
                           rsp.plain_low);
                  errors++;
               end
               beats_checked++;
            end
         end
      end
   end

   task automatic write_reg(csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
      if (idx <= CSR_KEY_WORD_3) begin
         key_words[idx] = value;
         rebuild_schedule();
      end else begin
         iv_words[idx - CSR_INIT_VECTOR_HI] = value;
      end
   endtask

   task automatic drain_pipeline();
      while (pending_ciphers.size() != 0 || expected_plain.size() != 0) begin
         @(negedge clock);
      end
      repeat (40) @(negedge clock);
   endtask

   task automatic load_key_iv(logic [63:0] k0, logic [63:0] k1, logic [63:0] k2,
                              logic [63:0] k3, logic [63:0] ivh, logic [63:0] ivl);
      write_reg(CSR_KEY_WORD_0, k0);
      write_reg(CSR_KEY_WORD_1, k1);
      write_reg(CSR_KEY_WORD_2, k2);
      write_reg(CSR_KEY_WORD_3, k3);
      write_reg(CSR_INIT_VECTOR_HI, ivh);
      write_reg(CSR_INIT_VECTOR_LO, ivl);
   endtask

   task automatic queue_cipher(logic [63:0] hi, logic [63:0] lo, logic first);
      cipher_beat_type b;
      b.cipher_high = hi;
      b.cipher_low = lo;
      b.first_block = first;
      if (first) firsts_sent++;
      pending_ciphers.push_back(b);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   initial begin
      int msg_len;
      key_words = '{default: '0};
      iv_words = '{default: '0};
      prev_cipher = '{default: '0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Known vector: FIPS-197 AES-256 with the chaining value at zero.
      load_key_iv(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
                  64'h18191a1b1c1d1e1f, 64'h0, 64'h0);
      queue_cipher(64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b0);
      queue_cipher(64'h0, 64'h0, 1'b0);
      queue_cipher(64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0);
      queue_cipher(64'h8000000000000000, 64'h0000000000000001, 1'b1);
      drain_pipeline();

      // Extreme keys and IVs, with first-block flags and plain chaining.
      load_key_iv('1, '1, '1, '1, '1, '1);
      queue_cipher('1, '1, 1'b1);
      queue_cipher('0, '0, 1'b0);
      queue_cipher('1, '0, 1'b0);
      queue_cipher('0, '1, 1'b1);
      drain_pipeline();
      load_key_iv('0, '0, '0, '0, '0, '0);
      queue_cipher('0, '0, 1'b1);
      queue_cipher(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
      drain_pipeline();

      // A lone IV change only lands on the next flagged block.
      write_reg(CSR_INIT_VECTOR_HI, 64'h5a5a5a5a5a5a5a5a);
      queue_cipher(rand64(), rand64(), 1'b0);
      queue_cipher(rand64(), rand64(), 1'b1);
      drain_pipeline();

      for (int phase = 0; phase < 12; phase++) begin
         send_gaps = (phase % 4) != 1;
         recv_stalls = (phase % 4) != 2;
         load_key_iv(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
         for (int n = 0; n < 130; n += msg_len) begin
            msg_len = $urandom_range(1, 20);
            for (int m = 0; m < msg_len; m++) begin
               queue_cipher(rand64(), rand64(), m == 0 ? 1'b1 : ($urandom_range(0, 19) == 0));
            end
         end
         drain_pipeline();
      end

      repeat (40) @(negedge clock);
      $display("Checked %0d plaintext beats over 15 key settings, %0d messages started.",
               beats_checked, firsts_sent);
      if (errors == 0) begin
         $display("aes256_cbc_decrypt_core regression: pass");
      end else begin
         $display("aes256_cbc_decrypt_core regression: fail");
      end
      $finish;
   end

endmodule

@@ aes256_cbc_decrypt_core.f @@
hdl/acbc_pkg.sv
hdl/acbc_channels.sv
hdl/acbc_key_expand.sv
hdl/aes256_cbc_decrypt_core.sv
tb/aes256_cbc_decrypt_core_testbench.sv
